@@ hdl/ffdc_pkg.sv @@
`default_nettype none

package ffdc_pkg;

   // Line framing codes
   localparam logic [7:0]  FLAG_BYTE  = 8'h7e;
   localparam logic [7:0]  ESC_BYTE   = 8'h7d;
   localparam logic [7:0]  ESC_XOR    = 8'h20;
   localparam logic [15:0] CRC_INIT   = 16'hffff;

   // Header check on byte 0: top two bits must read 10
   localparam logic [7:0]  HDR_MASK   = 8'hc0;
   localparam logic [7:0]  HDR_MARK   = 8'h80;

   // Status frame layout (decoded byte positions)
   localparam logic [7:0]  POS_NODE     = 8'd2;
   localparam logic [7:0]  POS_CNT_LO   = 8'd4;
   localparam logic [7:0]  POS_CRC_HI   = 8'd16;
   localparam logic [7:0]  POS_CRC_LO   = 8'd17;
   localparam logic [7:0]  POS_MAX      = 8'd255;

   // Register reset values
   localparam logic        RST_STRICT_MODE     = 1'b0;
   localparam logic [5:0]  RST_STATUS_PROTOCOL = 6'd49;
   localparam logic [7:0]  RST_NODE_MIN        = 8'd1;
   localparam logic [7:0]  RST_NODE_MAX        = 8'd5;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_STRICT_MODE     = 2'd0,
      CSR_STATUS_PROTOCOL = 2'd1,
      CSR_NODE_MIN        = 2'd2,
      CSR_NODE_MAX        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       strict_mode;
      logic [5:0] status_protocol;
      logic [7:0] node_min;
      logic [7:0] node_max;
   } cfg_type;

   typedef struct packed {
      logic        frame_start;
      logic        byte_valid;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        header_error;
      logic        node_ok;
      logic        counter_valid;
      logic [2:0]  counter_id;
      logic [15:0] counter_value;
      logic        crc_done;
      logic        crc_ok;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/ffdc_ifs.sv @@
`default_nettype none

// Raw line byte channel
interface ffdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink   (input valid, input line_byte, output ready);
endinterface

// Decoded result channel
interface ffdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_start;
   logic        byte_valid;
   logic [7:0]  data_byte;
   logic [7:0]  byte_index;
   logic        header_error;
   logic        node_ok;
   logic        counter_valid;
   logic [2:0]  counter_id;
   logic [15:0] counter_value;
   logic        crc_done;
   logic        crc_ok;

   modport source (output valid, output frame_start, output byte_valid, output data_byte,
                   output byte_index, output header_error, output node_ok,
                   output counter_valid, output counter_id, output counter_value,
                   output crc_done, output crc_ok, input ready);
   modport sink   (input valid, input frame_start, input byte_valid, input data_byte,
                   input byte_index, input header_error, input node_ok,
                   input counter_valid, input counter_id, input counter_value,
                   input crc_done, input crc_ok, output ready);
endinterface

// Register write channel
interface ffdc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/ffdc_csr.sv @@
`default_nettype none

module ffdc_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   ffdc_csr_if.sink              csr_ch,
   output ffdc_pkg::cfg_type     cfg
);
   import ffdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_STRICT_MODE:     cfg_in.strict_mode     = csr_ch.data[0];
            CSR_STATUS_PROTOCOL: cfg_in.status_protocol = csr_ch.data[5:0];
            CSR_NODE_MIN:        cfg_in.node_min        = csr_ch.data;
            CSR_NODE_MAX:        cfg_in.node_max        = csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict_mode     <= RST_STRICT_MODE;
         cfg_ff.status_protocol <= RST_STATUS_PROTOCOL;
         cfg_ff.node_min        <= RST_NODE_MIN;
         cfg_ff.node_max        <= RST_NODE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/ffdc_core.sv @@
`default_nettype none

module ffdc_core (
   input  wire logic               clock,
   input  wire logic               reset,
   ffdc_req_if.sink                req_ch,
   input  wire ffdc_pkg::cfg_type  cfg,
   input  wire logic               out_space,
   output logic                    res_valid,
   output ffdc_pkg::result_type    res
);
   import ffdc_pkg::*;

   // One CRC-CCITT (reflected) byte update
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  x;
      logic [15:0] r;
      x = b ^ crc[7:0];
      x = x ^ {x[3:0], 4'b0000};
      r = {x, crc[15:8]};
      r = r ^ {12'd0, x[7:4]} ^ {5'd0, x, 3'b000};
      return r;
   endfunction

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;

   logic        esc_ff,   esc_in;
   logic        sync_ff,  sync_in;
   logic [7:0]  pos_ff,   pos_in;
   logic [5:0]  proto_ff, proto_in;
   logic [15:0] crc_ff,   crc_in;
   logic [7:0]  held_ff,  held_in;
   logic [7:0]  rxcrc_ff, rxcrc_in;

   logic [7:0] dec;
   logic [5:0] proto_cur;
   logic       status;
   logic [7:0] cnt_off;

   // Input register: takes a new byte when empty or whenever the held one moves on
   assign advance      = in_valid_ff && out_space;
   assign req_ch.ready = !in_valid_ff || out_space;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.line_byte;
      end
   end

   // Unstuffing, field decode and CRC for the held byte
   assign dec       = esc_ff ? (in_byte_ff ^ ESC_XOR) : in_byte_ff;
   assign proto_cur = (pos_ff == 8'd0) ? dec[5:0] : proto_ff;
   assign status    = (proto_cur == cfg.status_protocol);
   assign cnt_off   = pos_ff - POS_CNT_LO;

   // Bytes out of sync and positions outside the status layout match no arm
   always_comb begin
      res      = '0;
      esc_in   = esc_ff;
      sync_in  = sync_ff;
      pos_in   = pos_ff;
      proto_in = proto_ff;
      crc_in   = crc_ff;
      held_in  = held_ff;
      rxcrc_in = rxcrc_ff;
      if (in_byte_ff == FLAG_BYTE) begin
         esc_in          = 1'b0;
         sync_in         = 1'b1;
         pos_in          = 8'd0;
         crc_in          = CRC_INIT;
         res.frame_start = 1'b1;
      end else if (in_byte_ff == ESC_BYTE && !esc_ff) begin
         esc_in = 1'b1;
      end else if (sync_ff) begin
         esc_in         = 1'b0;
         proto_in       = proto_cur;
         res.byte_valid = 1'b1;
         res.data_byte  = dec;
         res.byte_index = pos_ff;
         if (pos_ff < POS_CRC_HI) begin
            crc_in = crc_step(crc_ff, dec);
         end
         if (pos_ff == 8'd0 && cfg.strict_mode && (dec & HDR_MASK) != HDR_MARK) begin
            res.header_error = 1'b1;
            sync_in          = 1'b0;
         end else if (status) begin
            if (pos_ff == POS_NODE) begin
               res.node_ok = (dec >= cfg.node_min) && (dec <= cfg.node_max);
            end else if (pos_ff >= POS_CNT_LO && pos_ff < POS_CRC_HI) begin
               if (!pos_ff[0]) begin
                  held_in = dec;
               end else begin
                  res.counter_valid = 1'b1;
                  res.counter_id    = cnt_off[3:1];
                  res.counter_value = {held_ff, dec};
               end
            end else if (pos_ff == POS_CRC_HI) begin
               rxcrc_in = dec;
            end else if (pos_ff == POS_CRC_LO) begin
               res.crc_done = 1'b1;
               res.crc_ok   = (crc_ff[15:8] == rxcrc_ff) && (crc_ff[7:0] == dec);
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   // Frame state moves only when the held byte is passed on
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         sync_ff  <= 1'b0;
         pos_ff   <= 8'd0;
         proto_ff <= 6'd0;
         crc_ff   <= CRC_INIT;
         held_ff  <= 8'd0;
         rxcrc_ff <= 8'd0;
      end else if (advance) begin
         esc_ff   <= esc_in;
         sync_ff  <= sync_in;
         pos_ff   <= pos_in;
         proto_ff <= proto_in;
         crc_ff   <= crc_in;
         held_ff  <= held_in;
         rxcrc_ff <= rxcrc_in;
      end
   end

   assign res_valid = in_valid_ff;

endmodule

`default_nettype wire

@@ hdl/ffdc_out.sv @@
`default_nettype none

module ffdc_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 res_valid,
   input  wire ffdc_pkg::result_type res,
   output logic                      out_space,
   ffdc_rsp_if.source                rsp_ch
);
   import ffdc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   // Room for a new result when empty or the current one is taken now
   assign out_space = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_space) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_space && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_start   = out_res_ff.frame_start;
   assign rsp_ch.byte_valid    = out_res_ff.byte_valid;
   assign rsp_ch.data_byte     = out_res_ff.data_byte;
   assign rsp_ch.byte_index    = out_res_ff.byte_index;
   assign rsp_ch.header_error  = out_res_ff.header_error;
   assign rsp_ch.node_ok       = out_res_ff.node_ok;
   assign rsp_ch.counter_valid = out_res_ff.counter_valid;
   assign rsp_ch.counter_id    = out_res_ff.counter_id;
   assign rsp_ch.counter_value = out_res_ff.counter_value;
   assign rsp_ch.crc_done      = out_res_ff.crc_done;
   assign rsp_ch.crc_ok        = out_res_ff.crc_ok;

endmodule

`default_nettype wire

@@ hdl/flag_framed_deframer_crc_check.sv @@
// Flag-framed byte deframer with unstuffing, status-frame decode and CRC check.
// req_ch: one raw line byte per transfer (valid/ready). rsp_ch: exactly one
// result per line byte, in order: flag seen, decoded byte and its index, header
// error, node range check, 16-bit counters and the CRC verdict of status frames.
// csr_ch: register writes (index 0 strict mode, 1 status protocol, 2 node min,
// 3 node max); always ready, to be used only while the block is idle.
// A byte taken on req_ch is held in the input register and its result in the
// result register, from which it is offered on rsp_ch. Throughput: one byte per
// cycle while rsp_ch does not stall; the frame state is updated in the single
// stage between the two registers.
// Reset: out of sync, no pending escape, CRC 0xFFFF, both registers empty and
// the configuration at 0 / 49 / 1 / 5.
// Receiver stall: the result register holds its transfer, the input register
// keeps one more byte, and req_ch.ready then drops until rsp_ch moves.
`default_nettype none

module flag_framed_deframer_crc_check (
   input  wire logic  clock,
   input  wire logic  reset,
   ffdc_req_if.sink   req_ch,
   ffdc_rsp_if.source rsp_ch,
   ffdc_csr_if.sink   csr_ch
);
   import ffdc_pkg::*;

   cfg_type    cfg;
   result_type res;
   logic       res_valid;
   logic       out_space;

   ffdc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   ffdc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .out_space (out_space),
      .res_valid (res_valid),
      .res       (res)
   );

   ffdc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_space (out_space),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ffdc_pkg::*;

   localparam int CYCLE_LIMIT       = 200000;
   localparam int ITEMS_PER_SETTING = 300;

   typedef logic [7:0] octet_q [$];

   // Mirror of the deframer: register copy, frame state and the queue of
   // results still owed by the block
   class line_decode_model;
      logic        strict_mode;
      logic [5:0]  status_protocol;
      logic [7:0]  node_min;
      logic [7:0]  node_max;

      bit          escape_pending;
      bit          in_sync;
      logic [7:0]  position;
      logic [5:0]  protocol;
      logic [15:0] crc;
      logic [7:0]  held_high;
      logic [7:0]  crc_high;

      result_type  pending_results [$];
      int unsigned mismatches;

      function new();
         strict_mode     = RST_STRICT_MODE;
         status_protocol = RST_STATUS_PROTOCOL;
         node_min        = RST_NODE_MIN;
         node_max        = RST_NODE_MAX;
         escape_pending  = 1'b0;
         in_sync         = 1'b0;
         position        = '0;
         protocol        = '0;
         crc             = CRC_INIT;
         held_high       = '0;
         crc_high        = '0;
         mismatches      = 0;
      endfunction

      // Reflected CCITT update, one octet at a time
      static function logic [15:0] crc_update(logic [15:0] crc_in, logic [7:0] octet);
         logic [7:0]  x;
         logic [15:0] r;
         x = octet ^ crc_in[7:0];
         x = x ^ (x << 4);
         r = {x, crc_in[15:8]};
         r = r ^ {12'd0, x[7:4]} ^ ({8'd0, x} << 3);
         return r;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_STRICT_MODE:     strict_mode     = value[0];
            CSR_STATUS_PROTOCOL: status_protocol = value[5:0];
            CSR_NODE_MIN:        node_min        = value;
            CSR_NODE_MAX:        node_max        = value;
            default: ;
         endcase
      endfunction

      // One raw line octet in, exactly one result out
      function void take_line_byte(logic [7:0] line_byte);
         result_type res;
         logic [7:0] c;
         logic [7:0] idx;
         bit         status;
         res = '0;
         c   = line_byte;
         if (c == FLAG_BYTE) begin
            escape_pending  = 1'b0;
            in_sync         = 1'b1;
            position        = '0;
            crc             = CRC_INIT;
            res.frame_start = 1'b1;
         end else if (c == ESC_BYTE && !escape_pending) begin
            escape_pending = 1'b1;
         end else if (in_sync) begin
            if (escape_pending) begin
               escape_pending = 1'b0;
               c = c ^ ESC_XOR;
            end
            idx            = position;
            res.byte_valid = 1'b1;
            res.data_byte  = c;
            res.byte_index = idx;
            if (idx == 8'd0)
               protocol = c[5:0];
            status = (protocol == status_protocol);
            if (idx < POS_CRC_HI)
               crc = crc_update(crc, c);
            if (idx == 8'd0 && strict_mode && (c & HDR_MASK) != HDR_MARK) begin
               res.header_error = 1'b1;
               in_sync = 1'b0;
            end else if (status) begin
               if (idx == POS_NODE) begin
                  res.node_ok = (c >= node_min) && (c <= node_max);
               end else if (idx >= POS_CNT_LO && idx < POS_CRC_HI) begin
                  if (!idx[0]) begin
                     held_high = c;
                  end else begin
                     res.counter_valid = 1'b1;
                     res.counter_id    = 3'((idx - POS_CNT_LO) >> 1);
                     res.counter_value = {held_high, c};
                  end
               end else if (idx == POS_CRC_HI) begin
                  crc_high = c;
               end else if (idx == POS_CRC_LO) begin
                  res.crc_done = 1'b1;
                  res.crc_ok   = (crc == {crc_high, c});
               end
            end
            if (position != POS_MAX)
               position = position + 8'd1;
         end
         pending_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("frame_start",   want.frame_start,   got.frame_start);
         compare_field("byte_valid",    want.byte_valid,    got.byte_valid);
         compare_field("data_byte",     want.data_byte,     got.data_byte);
         compare_field("byte_index",    want.byte_index,    got.byte_index);
         compare_field("header_error",  want.header_error,  got.header_error);
         compare_field("node_ok",       want.node_ok,       got.node_ok);
         compare_field("counter_valid", want.counter_valid, got.counter_valid);
         compare_field("counter_id",    want.counter_id,    got.counter_id);
         compare_field("counter_value", want.counter_value, got.counter_value);
         compare_field("crc_done",      want.crc_done,      got.crc_done);
         compare_field("crc_ok",        want.crc_ok,        got.crc_ok);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffdc_req_if req_ch ();
   ffdc_rsp_if rsp_ch ();
   ffdc_csr_if csr_ch ();

   line_decode_model model;
   int unsigned      items_sent    = 0;
   int unsigned      send_idle_pct = 21;
   int unsigned      recv_idle_pct = 73;
   int unsigned      stall_request = 0;

   flag_framed_deframer_crc_check dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // CRC over the first sixteen octets of a frame body
   function automatic logic [15:0] crc_of(octet_q body);
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (body[i])
         if (i < 16)
            crc = line_decode_model::crc_update(crc, body[i]);
      return crc;
   endfunction

   // One line octet; random gaps before it, held until the transfer
   task automatic send_byte(input logic [7:0] octet);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.line_byte <= octet;
      do
         @(posedge clock);
      while (!req_ch.ready);
      model.take_line_byte(octet);
      items_sent++;
   endtask

   // Opening flag, then the body with stuffing; some plain octets are escaped too
   task automatic send_frame(input octet_q body);
      send_byte(FLAG_BYTE);
      foreach (body[i]) begin
         if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE ||
             ($urandom_range(9) == 0 && body[i] != (FLAG_BYTE ^ ESC_XOR))) begin
            send_byte(ESC_BYTE);
            send_byte(body[i] ^ ESC_XOR);
         end else begin
            send_byte(body[i]);
         end
      end
   endtask

   task automatic send_random_frame(input bit long_frame);
      octet_q      body;
      logic [15:0] crc;
      logic [15:0] count_val;
      logic [7:0]  head;
      int          kind;
      int          extra;
      int          keep;
      kind  = long_frame ? (($urandom_range(1) == 0) ? 0 : 70) : $urandom_range(99);
      extra = 0;
      if (kind < 60) begin
         // status frame, header mostly well formed for strict mode
         head = {2'b10, model.status_protocol};
         if ($urandom_range(5) == 0)
            head[7:6] = 2'($urandom_range(3));
         body.push_back(head);
         body.push_back(8'($urandom));
         case ($urandom_range(4))
            0:       body.push_back(model.node_min);
            1:       body.push_back(model.node_max);
            2:       body.push_back(model.node_min - 8'd1);
            3:       body.push_back(model.node_max + 8'd1);
            default: body.push_back(8'($urandom));
         endcase
         body.push_back(8'($urandom));
         repeat (6) begin
            case ($urandom_range(3))
               0:       count_val = 16'h0000;
               1:       count_val = 16'hffff;
               default: count_val = 16'($urandom);
            endcase
            body.push_back(count_val[15:8]);
            body.push_back(count_val[7:0]);
         end
         crc = crc_of(body);
         if ($urandom_range(5) == 0)
            crc = crc ^ (16'd1 << $urandom_range(15));
         body.push_back(crc[15:8]);
         body.push_back(crc[7:0]);
         // cut short now and then, so the next flag breaks in
         if ($urandom_range(7) == 0) begin
            keep = $urandom_range(17, 1);
            while (body.size() > keep)
               void'(body.pop_back());
         end
         if (long_frame)
            extra = $urandom_range(250, 240);
         else if ($urandom_range(4) == 0)
            extra = $urandom_range(4, 1);
      end else if (kind < 85) begin
         body.push_back(8'($urandom));
         extra = long_frame ? $urandom_range(264, 258) : $urandom_range(23);
      end else begin
         // raw line noise, rich in flags and escapes
         repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3))
               0:       send_byte(ESC_BYTE);
               1:       send_byte(FLAG_BYTE);
               default: send_byte(8'($urandom));
            endcase
         end
         return;
      end
      repeat (extra)
         body.push_back(8'($urandom));
      send_frame(body);
   endtask

   // Stop offering and wait for every owed result
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (model.pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_transfer(input csr_index_type idx, input logic [7:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      model.write_reg(idx, value);
   endtask

   task automatic apply_setting(input cfg_type s);
      csr_transfer(CSR_STRICT_MODE, {7'd0, s.strict_mode});
      csr_transfer(CSR_STATUS_PROTOCOL, {2'd0, s.status_protocol});
      csr_transfer(CSR_NODE_MIN, s.node_min);
      csr_transfer(CSR_NODE_MAX, s.node_max);
      csr_ch.valid <= 1'b0;
   endtask

   // Result side: check each transfer, then pick ready for the next edge
   initial begin : result_sink
      int unsigned hold_left;
      result_type  got;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{frame_start:   rsp_ch.frame_start,
                    byte_valid:    rsp_ch.byte_valid,
                    data_byte:     rsp_ch.data_byte,
                    byte_index:    rsp_ch.byte_index,
                    header_error:  rsp_ch.header_error,
                    node_ok:       rsp_ch.node_ok,
                    counter_valid: rsp_ch.counter_valid,
                    counter_id:    rsp_ch.counter_id,
                    counter_value: rsp_ch.counter_value,
                    crc_done:      rsp_ch.crc_done,
                    crc_ok:        rsp_ch.crc_ok};
            model.check_result(got);
         end
         if (stall_request != 0) begin
            hold_left     = stall_request;
            stall_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      cfg_type     settings [6];
      octet_q      body;
      logic [15:0] crc;
      int unsigned phase_start;
      bit          stall_done;
      bit          pause_done;
      model = new();
      req_ch.valid     <= 1'b0;
      req_ch.line_byte <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_STRICT_MODE;
      csr_ch.data      <= '0;
      stall_done = 1'b0;
      pause_done = 1'b0;

      // extremes: strict on/off, protocol 0 and 63, empty and full node ranges
      settings[0] = '{strict_mode: 1'b1, status_protocol: 6'd49, node_min: 8'd1,   node_max: 8'd5};
      settings[1] = '{strict_mode: 1'b0, status_protocol: 6'd0,  node_min: 8'd0,   node_max: 8'd255};
      settings[2] = '{strict_mode: 1'b1, status_protocol: 6'd63, node_min: 8'd255, node_max: 8'd0};
      settings[3] = '{strict_mode: 1'b0, status_protocol: 6'd17, node_min: 8'd40,  node_max: 8'd40};
      settings[4] = '{strict_mode: 1'b1, status_protocol: 6'd49, node_min: 8'd0,   node_max: 8'd0};
      settings[5] = '{strict_mode: 1'b0, status_protocol: 6'd63, node_min: 8'd255, node_max: 8'd255};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // out of sync: plain octet, escape, escape while pending, another octet
      send_byte(8'h00);
      send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      send_byte(8'hff);
      // flag, then a double escape decoding to 0x5d as octet 0
      send_byte(FLAG_BYTE);
      send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      // well-formed status frame at reset settings, counters including their extremes
      body = '{8'hb1, 8'h00, 8'h05, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff,
               8'h12, 8'h34, FLAG_BYTE, ESC_BYTE, 8'h80, 8'h01, 8'h00, 8'hff};
      crc = crc_of(body);
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      send_frame(body);

      // random frames under each setting and idling pattern
      for (int s = 0; s < 6; s++) begin
         wait_drained();
         apply_setting(settings[s]);
         send_idle_pct = (s < 2) ? 21 : (s < 4) ? 73 : 0;
         recv_idle_pct = (s < 2) ? 73 : (s < 4) ? 21 : 0;
         phase_start   = items_sent;
         if (s == 0 || s == 3)
            send_random_frame(1'b1);
         while (items_sent - phase_start < ITEMS_PER_SETTING) begin
            send_random_frame(1'b0);
            if (s == 1 && !stall_done && items_sent - phase_start > 150) begin
               stall_request = 150;
               stall_done    = 1'b1;
            end
            if (s == 2 && !pause_done && items_sent - phase_start > 150) begin
               wait_drained();
               pause_done = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (model.pending_results.size() != 0)
         $display("%0t: %0d expected results never arrived", $time,
                  model.pending_results.size());
      if (model.mismatches == 0 && model.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
